@@ rtl/led_strip_animation_engine_assert.svh @@
// ----------------------------------------------------------------------------
// LED strip animation engine assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef LED_STRIP_ANIMATION_ENGINE_ASSERT_SVH
`define LED_STRIP_ANIMATION_ENGINE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LSAE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define LSAE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/lsae_pkg.sv @@
// ----------------------------------------------------------------------------
// LED strip animation engine package
// Widths, codes, sequencer states and the per-pixel control struct.
// ----------------------------------------------------------------------------
package lsae_pkg;

	localparam int STRIP_MAX    = 64;
	localparam int STORE_DEPTH  = 64;
	localparam int IDX_W        = 6;
	localparam int CNT_W        = 7;
	localparam int CH_W         = 8;
	localparam int COLOR_W      = 24;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 24;
	localparam int FADE_DIVISOR = 2;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_COLOR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_COLOR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_LEN   = 3'd4;

	// item function codes
	typedef enum logic [1:0] {
		FN_TICK      = 2'd0,
		FN_WRITE_ONE = 2'd1,
		FN_WRITE_ALL = 2'd2,
		FN_START     = 2'd3
	} func_t;

	// animation modes
	typedef enum logic [2:0] {
		MODE_NONE    = 3'd0,
		MODE_BLINK   = 3'd1,
		MODE_FADE    = 3'd2,
		MODE_BREATHE = 3'd3,
		MODE_SCROLL  = 3'd4
	} mode_t;

	// what one sweep over the strip does to each pixel
	typedef enum logic [2:0] {
		OP_STORE,
		OP_BLACK,
		OP_FILL_EMIT,
		OP_FILL,
		OP_FADE,
		OP_CONST,
		OP_SCROLL
	} sweep_op_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MODQ,
		ST_RD,
		ST_CALC
	} state_t;

	// per-pixel control into the color unit
	typedef struct packed {
		sweep_op_t op;
		logic      in_window;
	} pix_ctl_t;

endpackage

@@ rtl/lsae_pixel_ram.sv @@
// ----------------------------------------------------------------------------
// LSAE pixel store
// 64 x 24 pixel memory, one write and one registered read port; per-entry
// valid bits make unwritten entries read as black right after reset.
// ----------------------------------------------------------------------------
module lsae_pixel_ram (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  we,
	input  logic [lsae_pkg::IDX_W-1:0]            waddr,
	input  logic [lsae_pkg::COLOR_W-1:0]          wdata,
	input  logic                                  re,
	input  logic [lsae_pkg::IDX_W-1:0]            raddr,
	output logic [lsae_pkg::COLOR_W-1:0]          rdata
);
	import lsae_pkg::*;

	logic [COLOR_W-1:0]     mem [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] vld_q;
	logic [COLOR_W-1:0]     rd_q;
	logic                   rd_vld_q;

	// storage array
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (re) begin
			rd_q     <= mem[raddr];
			rd_vld_q <= vld_q[raddr];
		end
	end

	assign rdata = rd_vld_q ? rd_q : '0;

endmodule

@@ rtl/lsae_color_unit.sv @@
// ----------------------------------------------------------------------------
// LSAE color unit
// Shared per-pixel color datapath used on every step of a sweep, plus the
// breathe channel stepper used once per breathe tick.
// ----------------------------------------------------------------------------
module lsae_color_unit (
	input  lsae_pkg::pix_ctl_t                    ctl,
	input  logic [lsae_pkg::COLOR_W-1:0]          store_color,
	input  logic [lsae_pkg::COLOR_W-1:0]          fill_color,
	input  logic [lsae_pkg::COLOR_W-1:0]          high_color,
	input  logic [lsae_pkg::COLOR_W-1:0]          low_color,
	input  logic [lsae_pkg::COLOR_W-1:0]          breath_color,
	input  logic                                  rising,
	output logic [lsae_pkg::COLOR_W-1:0]          pix_color,
	output logic [lsae_pkg::COLOR_W-1:0]          breath_next,
	output logic                                  rising_next
);
	import lsae_pkg::*;

	logic [COLOR_W-1:0] halved;
	logic [COLOR_W-1:0] target;
	logic               all_hit;
	logic [CH_W-1:0]    cur_ch;
	logic [CH_W-1:0]    tgt_ch;

	// fade: each channel halved
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			halved[k*CH_W +: CH_W] = CH_W'(store_color[k*CH_W +: CH_W] / FADE_DIVISOR);
		end
	end

	// per-pixel color select
	always_comb begin
		case (ctl.op)
			OP_STORE:     pix_color = store_color;
			OP_BLACK:     pix_color = '0;
			OP_FILL_EMIT: pix_color = fill_color;
			OP_FILL:      pix_color = fill_color;
			OP_FADE:      pix_color = halved;
			OP_CONST:     pix_color = fill_color;
			OP_SCROLL:    pix_color = ctl.in_window ? high_color : low_color;
			default:      pix_color = '0;
		endcase
	end

	// breathe: step each channel by one toward the target
	always_comb begin
		target  = rising ? high_color : low_color;
		all_hit = 1'b1;
		cur_ch  = '0;
		tgt_ch  = '0;
		for (int k = 0; k < 3; k++) begin
			cur_ch = breath_color[k*CH_W +: CH_W];
			tgt_ch = target[k*CH_W +: CH_W];
			if (rising) begin
				if (cur_ch < tgt_ch) begin
					cur_ch = cur_ch + 8'd1;
				end
			end else begin
				if (cur_ch > tgt_ch) begin
					cur_ch = cur_ch - 8'd1;
				end
			end
			breath_next[k*CH_W +: CH_W] = cur_ch;
			if (cur_ch != tgt_ch) begin
				all_hit = 1'b0;
			end
		end
		rising_next = all_hit ? !rising : rising;
	end

endmodule

@@ rtl/led_strip_animation_engine.sv @@
// The first pixel of a frame passes the read state, the calc state and the
// output register after the item is taken. Each pixel takes a read and a calc
// state, as the pixel store has a registered read port; no new item is taken
// until the frame is done. Scroll ticks first reduce the window start in ST_MODQ.
// Starts of blink and scroll refill the store with no result.
// Reset initialises all control state; the store reads as black via valid bits.
// ----------------------------------------------------------------------------
// LED strip animation engine
// Pixel store with blink, fade, breathe and scroll animations; each write or
// running tick sends the whole frame out one pixel at a time.
// ----------------------------------------------------------------------------
module led_strip_animation_engine (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration
	input  logic                                  cfg_we,
	input  logic [lsae_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [lsae_pkg::CFG_DATA_W-1:0]       cfg_data,
	// input items
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [1:0]                            func,
	input  logic [lsae_pkg::IDX_W-1:0]            pixel_index,
	input  logic [lsae_pkg::CH_W-1:0]             red_in,
	input  logic [lsae_pkg::CH_W-1:0]             green_in,
	input  logic [lsae_pkg::CH_W-1:0]             blue_in,
	// result items
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [lsae_pkg::IDX_W-1:0]            out_index,
	output logic [lsae_pkg::CH_W-1:0]             red_out,
	output logic [lsae_pkg::CH_W-1:0]             green_out,
	output logic [lsae_pkg::CH_W-1:0]             blue_out,
	output logic                                  frame_end
);
	import lsae_pkg::*;
	`include "led_strip_animation_engine_assert.svh"

	// config registers
	logic [2:0]         mode_q;
	logic [CNT_W-1:0]   led_count_q;
	logic [COLOR_W-1:0] low_q;
	logic [COLOR_W-1:0] high_q;
	logic [CNT_W-1:0]   wlen_q;

	// animation and sweep state
	state_t             state_q;
	state_t             state_d;
	sweep_op_t          op_q;
	logic [CNT_W-1:0]   i_q;
	logic [CNT_W-1:0]   d_q;
	logic [IDX_W-1:0]   ws_q;
	logic [COLOR_W-1:0] fill_q;
	logic [COLOR_W-1:0] breath_q;
	logic               running_q;
	logic               phase_q;
	logic               rising_q;
	logic               all_off_q;

	// output register
	logic               out_valid_q;
	logic [IDX_W-1:0]   out_index_q;
	logic [COLOR_W-1:0] out_color_q;
	logic               frame_end_q;

	logic [CNT_W-1:0]   n;
	logic               accept;
	logic [COLOR_W-1:0] in_color;
	logic               out_free;
	logic               emit;
	logic               wr;
	logic               adv;
	logic               last;
	logic               ws_big;
	pix_ctl_t           ctl;
	logic [COLOR_W-1:0] store_color;
	logic [COLOR_W-1:0] pix_color;
	logic [COLOR_W-1:0] breath_next;
	logic               rising_next;
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [COLOR_W-1:0] ram_wdata;
	logic               ram_re;

	// effective strip length
	always_comb begin
		if (led_count_q == '0) begin
			n = CNT_W'(1);
		end else if (led_count_q > CNT_W'(STRIP_MAX)) begin
			n = CNT_W'(STRIP_MAX);
		end else begin
			n = led_count_q;
		end
	end

	assign in_color = {red_in, green_in, blue_in};
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign last     = (i_q + CNT_W'(1)) == n;
	assign ws_big   = {1'b0, ws_q} >= n;

	// sweep op decode
	always_comb begin
		emit = (op_q != OP_FILL);
		wr   = (op_q == OP_FILL_EMIT) || (op_q == OP_FILL) ||
		       (op_q == OP_FADE) || (op_q == OP_SCROLL);
	end

	assign ctl.op        = op_q;
	assign ctl.in_window = d_q < wlen_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (func)
						FN_WRITE_ONE, FN_WRITE_ALL: state_d = ST_RD;
						FN_START: begin
							if (mode_q == MODE_BLINK || mode_q == MODE_SCROLL) begin
								state_d = ST_RD;
							end
						end
						default: begin
							if (running_q) begin
								if (mode_q == MODE_BLINK || mode_q == MODE_FADE ||
								    mode_q == MODE_BREATHE) begin
									state_d = ST_RD;
								end else if (mode_q == MODE_SCROLL) begin
									state_d = ST_MODQ;
								end
							end
						end
					endcase
				end
			end
			ST_MODQ: begin
				if (!ws_big) begin
					state_d = ST_RD;
				end
			end
			ST_RD: state_d = ST_CALC;
			ST_CALC: begin
				if (adv) begin
					state_d = last ? ST_IDLE : ST_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		ram_re    = (state_q == ST_RD);
		adv       = (state_q == ST_CALC) && (!emit || out_free);
		ram_we    = 1'b0;
		ram_waddr = i_q[IDX_W-1:0];
		ram_wdata = pix_color;
		case (state_q)
			ST_IDLE: begin
				if (accept && func == FN_WRITE_ONE) begin
					ram_we    = 1'b1;
					ram_waddr = pixel_index;
					ram_wdata = in_color;
				end
			end
			ST_CALC: begin
				ram_we = adv && wr;
			end
			default: ram_we = 1'b0;
		endcase
	end

	// pixel store
	lsae_pixel_ram u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.re     (ram_re),
		.raddr  (i_q[IDX_W-1:0]),
		.rdata  (store_color)
	);

	// shared color datapath
	lsae_color_unit u_color (
		.ctl          (ctl),
		.store_color  (store_color),
		.fill_color   (fill_q),
		.high_color   (high_q),
		.low_color    (low_q),
		.breath_color (breath_q),
		.rising       (rising_q),
		.pix_color    (pix_color),
		.breath_next  (breath_next),
		.rising_next  (rising_next)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_NONE;
			led_count_q <= CNT_W'(64);
			low_q       <= '0;
			high_q      <= '0;
			wlen_q      <= CNT_W'(3);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:       mode_q      <= cfg_data[2:0];
				REG_LED_COUNT:  led_count_q <= cfg_data[CNT_W-1:0];
				REG_LOW_COLOR:  low_q       <= cfg_data[COLOR_W-1:0];
				REG_HIGH_COLOR: high_q      <= cfg_data[COLOR_W-1:0];
				REG_WIN_LEN:    wlen_q      <= cfg_data[CNT_W-1:0];
				default:        mode_q      <= mode_q;
			endcase
		end
	end

	// sequencer and animation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			op_q      <= OP_STORE;
			i_q       <= '0;
			d_q       <= '0;
			ws_q      <= '0;
			fill_q    <= '0;
			breath_q  <= '0;
			running_q <= 1'b0;
			phase_q   <= 1'b1;
			rising_q  <= 1'b1;
			all_off_q <= 1'b1;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						i_q       <= '0;
						all_off_q <= 1'b1;
						case (func)
							FN_WRITE_ONE: begin
								running_q <= 1'b0;
								op_q      <= OP_STORE;
							end
							FN_WRITE_ALL: begin
								running_q <= 1'b0;
								op_q      <= OP_FILL_EMIT;
								fill_q    <= in_color;
							end
							FN_START: begin
								case (mode_q)
									MODE_BLINK: begin
										op_q      <= OP_FILL;
										fill_q    <= high_q;
										phase_q   <= 1'b1;
										running_q <= 1'b1;
									end
									MODE_FADE: running_q <= 1'b1;
									MODE_BREATHE: begin
										breath_q  <= low_q;
										rising_q  <= 1'b1;
										running_q <= 1'b1;
									end
									MODE_SCROLL: begin
										op_q      <= OP_FILL;
										fill_q    <= low_q;
										ws_q      <= '0;
										running_q <= 1'b1;
									end
									default: running_q <= 1'b0;
								endcase
							end
							default: begin
								if (running_q) begin
									case (mode_q)
										MODE_BLINK: begin
											op_q    <= phase_q ? OP_STORE : OP_BLACK;
											phase_q <= !phase_q;
										end
										MODE_FADE: op_q <= OP_FADE;
										MODE_BREATHE: begin
											op_q     <= OP_CONST;
											breath_q <= breath_next;
											fill_q   <= breath_next;
											rising_q <= rising_next;
										end
										MODE_SCROLL: op_q <= OP_SCROLL;
										default: op_q <= op_q;
									endcase
								end
							end
						endcase
					end
				end
				ST_MODQ: begin
					// bring the window start into the strip, then set the
					// distance counter and the next tick's start
					if (ws_big) begin
						ws_q <= ws_q - n[IDX_W-1:0];
					end else begin
						d_q  <= (ws_q == '0) ? '0 : n - {1'b0, ws_q};
						ws_q <= ({1'b0, ws_q} + CNT_W'(1) == n) ? '0 : ws_q + IDX_W'(1);
					end
				end
				ST_CALC: begin
					if (adv) begin
						i_q <= i_q + CNT_W'(1);
						d_q <= (d_q + CNT_W'(1) == n) ? '0 : d_q + CNT_W'(1);
						if (op_q == OP_FADE) begin
							all_off_q <= all_off_q && (pix_color == '0);
							if (last && all_off_q && pix_color == '0) begin
								running_q <= 1'b0;
							end
						end
					end
				end
				default: i_q <= i_q;
			endcase
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (adv && emit) begin
			out_index_q <= i_q[IDX_W-1:0];
			out_color_q <= pix_color;
			frame_end_q <= last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_index = out_index_q;
	assign red_out   = out_color_q[2*CH_W +: CH_W];
	assign green_out = out_color_q[CH_W +: CH_W];
	assign blue_out  = out_color_q[0 +: CH_W];
	assign frame_end = frame_end_q;

	// checks
	`LSAE_ASSERT_IMP(a_mid_frame_busy, clk, arst_n, out_valid && !frame_end, state_q != ST_IDLE, "pixel waiting but frame sweep not active")
	`LSAE_ASSERT_IMP(a_modq_running, clk, arst_n, state_q == ST_MODQ, running_q, "window reduction without running scroll")
	`LSAE_ASSERT_NXT(a_write_stops, clk, arst_n, accept && (func == FN_WRITE_ONE || func == FN_WRITE_ALL), !running_q, "pixel write left animation running")

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// LED strip animation engine testbench
// Drives pixel writes, animation starts and timer ticks with random gaps on
// both handshakes. The frame engine model, or a directed row's own expectation,
// predicts every emitted pixel, and each accepted pixel is compared to the oldest
// prediction. Register settings change between phases once the engine is idle.
// ----------------------------------------------------------------------------
module tb_top;
	import lsae_pkg::*;

	localparam int LIMIT_CYCLES = 600000;
	localparam int SETTLE_CYCLES = 200;
	localparam int REPORT_MAX = 10;
	localparam int RANDOM_ITEMS = 135;

	// one emitted pixel
	typedef struct {
		logic [IDX_W-1:0] pos;
		logic [CH_W-1:0]  red;
		logic [CH_W-1:0]  green;
		logic [CH_W-1:0]  blue;
		logic             fend;
	} pixel_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	// one row of the stimulus plan: a register write or an item
	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  sel;
		logic [CFG_DATA_W-1:0] val;
		func_t                 fn;
		logic [IDX_W-1:0]      pos;
		logic [COLOR_W-1:0]    rgb;
		bit                    typed;
		int                    exp_cnt;
		logic [COLOR_W-1:0]    exp_rgb;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [1:0] func;
	logic [IDX_W-1:0] pixel_index;
	logic [CH_W-1:0] red_in, green_in, blue_in;
	logic out_valid;
	logic out_stall;
	logic [IDX_W-1:0] out_index;
	logic [CH_W-1:0] red_out, green_out, blue_out;
	logic frame_end;

	// model of the engine's registers and state
	logic [2:0] cfg_mode;
	logic [6:0] cfg_count;
	logic [COLOR_W-1:0] cfg_low, cfg_high;
	logic [6:0] cfg_win;
	logic [COLOR_W-1:0] shadow_store [STRIP_MAX];
	bit anim_on, blink_lit, breath_up;
	logic [COLOR_W-1:0] breath_rgb;
	int unsigned win_pos;

	pixel_t frame_next[$];
	pixel_t frame_q[$];

	bit quiet;
	int mismatches;
	int cycles;
	int pixels_seen;
	int directed_items;
	int random_items;
	int settings;
	int phase;
	bit cfg_open;
	plan_row_t plan[$];

	led_strip_animation_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.pixel_index(pixel_index),
		.red_in(red_in),
		.green_in(green_in),
		.blue_in(blue_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_index(out_index),
		.red_out(red_out),
		.green_out(green_out),
		.blue_out(blue_out),
		.frame_end(frame_end)
	);

	always #2 clk = ~clk;

	// strip length with out-of-range counts clamped
	function automatic int strip_len();
		if (cfg_count == 0) return 1;
		if (cfg_count > STRIP_MAX) return STRIP_MAX;
		return int'(cfg_count);
	endfunction

	// queue a whole frame, from the store or one flat color
	function automatic void emit_frame(input bit from_store, input logic [COLOR_W-1:0] fill);
		int n;
		logic [COLOR_W-1:0] c;
		pixel_t px;
		n = strip_len();
		for (int i = 0; i < n; i++) begin
			c = from_store ? shadow_store[i] : fill;
			px.pos = i[IDX_W-1:0];
			px.red = c[23:16];
			px.green = c[15:8];
			px.blue = c[7:0];
			px.fend = (i == n - 1);
			frame_next.push_back(px);
		end
	endfunction

	// advance the engine model by one item, results land in frame_next
	function automatic void frame_engine(input func_t fn, input logic [IDX_W-1:0] pos,
			input logic [COLOR_W-1:0] rgb);
		int n, len;
		bit lit, all_off, hit;
		logic [COLOR_W-1:0] tgt, nb;
		logic [CH_W-1:0] c, t;
		frame_next.delete();
		n = strip_len();
		case (fn)
			FN_WRITE_ONE: begin
				anim_on = 0;
				shadow_store[pos] = rgb;
				emit_frame(1, '0);
			end
			FN_WRITE_ALL: begin
				anim_on = 0;
				for (int i = 0; i < n; i++) shadow_store[i] = rgb;
				emit_frame(1, '0);
			end
			FN_START: begin
				case (cfg_mode)
					MODE_BLINK: begin
						for (int i = 0; i < n; i++) shadow_store[i] = cfg_high;
						blink_lit = 1;
						anim_on = 1;
					end
					MODE_FADE: anim_on = 1;
					MODE_BREATHE: begin
						breath_rgb = cfg_low;
						breath_up = 1;
						anim_on = 1;
					end
					MODE_SCROLL: begin
						win_pos = 0;
						for (int i = 0; i < n; i++) shadow_store[i] = cfg_low;
						anim_on = 1;
					end
					default: anim_on = 0;
				endcase
			end
			default: begin
				// timer tick, only while an animation runs
				if (anim_on) begin
					case (cfg_mode)
						MODE_BLINK: begin
							lit = blink_lit;
							blink_lit = !blink_lit;
							emit_frame(lit, '0);
						end
						MODE_FADE: begin
							all_off = 1;
							for (int i = 0; i < n; i++) begin
								shadow_store[i] = (shadow_store[i] >> 1) & 24'h7F7F7F;
								if (shadow_store[i] != 0) all_off = 0;
							end
							if (all_off) anim_on = 0;
							emit_frame(1, '0);
						end
						MODE_BREATHE: begin
							tgt = breath_up ? cfg_high : cfg_low;
							hit = 1;
							for (int ch = 0; ch < 3; ch++) begin
								c = breath_rgb[ch*8 +: 8];
								t = tgt[ch*8 +: 8];
								if (breath_up && c < t) c = c + 8'd1;
								if (!breath_up && c > t) c = c - 8'd1;
								nb[ch*8 +: 8] = c;
								if (c != t) hit = 0;
							end
							breath_rgb = nb;
							if (hit) breath_up = !breath_up;
							emit_frame(0, breath_rgb);
						end
						MODE_SCROLL: begin
							len = (cfg_win < n) ? int'(cfg_win) : n;
							for (int i = 0; i < n; i++) shadow_store[i] = cfg_low;
							for (int i = 0; i < len; i++)
								shadow_store[(win_pos + i) % n] = cfg_high;
							win_pos = ((win_pos + 1) % n) & 63;
							emit_frame(1, '0);
						end
						default: ;
					endcase
				end
			end
		endcase
	endfunction

	// plan row builders
	function automatic plan_row_t item_row(input func_t fn, input logic [IDX_W-1:0] pos,
			input logic [COLOR_W-1:0] rgb);
		plan_row_t r;
		r = '{kind: ROW_ITEM, fn: FN_TICK, default: '0};
		r.kind = ROW_ITEM;
		r.fn = fn;
		r.pos = pos;
		r.rgb = rgb;
		return r;
	endfunction

	function automatic plan_row_t typed_row(input func_t fn, input logic [IDX_W-1:0] pos,
			input logic [COLOR_W-1:0] rgb, input int cnt, input logic [COLOR_W-1:0] exp_rgb);
		plan_row_t r;
		r = item_row(fn, pos, rgb);
		r.typed = 1;
		r.exp_cnt = cnt;
		r.exp_rgb = exp_rgb;
		return r;
	endfunction

	function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] sel,
			input logic [CFG_DATA_W-1:0] val);
		plan_row_t r;
		r = '{kind: ROW_CFG, fn: FN_TICK, default: '0};
		r.kind = ROW_CFG;
		r.sel = sel;
		r.val = val;
		return r;
	endfunction

	function automatic bit idle_roll();
		return !quiet && ($urandom_range(0, 99) < 35);
	endfunction

	function automatic logic [COLOR_W-1:0] pick_color();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return 24'h000000;
		if (r < 20) return 24'hFFFFFF;
		if (r < 45) return COLOR_W'($urandom & 32'h00030303);
		return COLOR_W'($urandom & 32'h00FFFFFF);
	endfunction

	// register write, called at a falling edge; cfg_we is lowered by send_item
	task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= val;
		case (sel)
			REG_MODE:       cfg_mode = val[2:0];
			REG_LED_COUNT:  cfg_count = val[6:0];
			REG_LOW_COLOR:  cfg_low = val[23:0];
			REG_HIGH_COLOR: cfg_high = val[23:0];
			REG_WIN_LEN:    cfg_win = val[6:0];
			default: ;
		endcase
		cfg_open = 1;
		@(negedge clk);
	endtask

	// wait until every predicted pixel is out and the engine has settled
	task automatic drain();
		in_valid <= 1'b0;
		while (frame_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// offer one item, predict its pixels once it is taken
	task automatic send_item(input plan_row_t row);
		pixel_t px;
		if (cfg_open) begin
			cfg_we <= 1'b0;
			cfg_open = 0;
		end
		while (idle_roll()) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= row.fn;
		pixel_index <= row.pos;
		red_in <= row.rgb[23:16];
		green_in <= row.rgb[15:8];
		blue_in <= row.rgb[7:0];
		@(posedge clk);
		while (in_stall) @(posedge clk);
		frame_engine(row.fn, row.pos, row.rgb);
		if (row.typed) begin
			for (int i = 0; i < row.exp_cnt; i++) begin
				px.pos = i[IDX_W-1:0];
				px.red = row.exp_rgb[23:16];
				px.green = row.exp_rgb[15:8];
				px.blue = row.exp_rgb[7:0];
				px.fend = (i == row.exp_cnt - 1);
				frame_q.push_back(px);
			end
		end else begin
			foreach (frame_next[i]) frame_q.push_back(frame_next[i]);
		end
		@(negedge clk);
	endtask

	function automatic void report(input string what, input pixel_t want, input pixel_t got);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("%s: expected pos=%0d rgb=%02h%02h%02h end=%0b, got pos=%0d rgb=%02h%02h%02h end=%0b",
				what, want.pos, want.red, want.green, want.blue, want.fend,
				got.pos, got.red, got.green, got.blue, got.fend);
	endfunction

	// receiver stall
	always @(negedge clk)
		out_stall <= arst_n && idle_roll();

	// pixel checker
	always @(posedge clk) begin
		pixel_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got.pos = out_index;
			got.red = red_out;
			got.green = green_out;
			got.blue = blue_out;
			got.fend = frame_end;
			pixels_seen++;
			if (frame_q.size() == 0) begin
				want = '{default: '0};
				report("unexpected pixel", want, got);
			end else begin
				want = frame_q.pop_front();
				if (got.pos !== want.pos || got.red !== want.red ||
						got.green !== want.green || got.blue !== want.blue ||
						got.fend !== want.fend)
					report("pixel mismatch", want, got);
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("timeout with %0d pixels outstanding", frame_q.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		plan_row_t row;
		bit started;
		int r, n_items;
		logic [CFG_DATA_W-1:0] v;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		func = '0;
		pixel_index = '0;
		red_in = '0;
		green_in = '0;
		blue_in = '0;
		out_stall = 1'b0;
		quiet = 0;
		mismatches = 0;
		cycles = 0;
		pixels_seen = 0;
		directed_items = 0;
		random_items = 0;
		settings = 1;
		cfg_open = 0;

		// model state after reset
		cfg_mode = MODE_NONE;
		cfg_count = 7'd64;
		cfg_low = '0;
		cfg_high = '0;
		cfg_win = 7'd3;
		foreach (shadow_store[i]) shadow_store[i] = '0;
		anim_on = 0;
		blink_lit = 1;
		breath_up = 1;
		breath_rgb = '0;
		win_pos = 0;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed plan: reset values, extremes and each corner of the animations
		plan.push_back(typed_row(FN_TICK, 6'd0, 24'h000000, 0, 24'h0));
		plan.push_back(typed_row(FN_WRITE_ALL, 6'd0, 24'hFFFFFF, 64, 24'hFFFFFF));
		plan.push_back(item_row(FN_WRITE_ONE, 6'd63, 24'h000000));
		plan.push_back(typed_row(FN_START, 6'd0, 24'h000000, 0, 24'h0));
		// blink on a five pixel strip, then a write past the strip
		plan.push_back(cfg_row(REG_LED_COUNT, 24'd5));
		plan.push_back(cfg_row(REG_MODE, MODE_BLINK));
		plan.push_back(cfg_row(REG_HIGH_COLOR, 24'hA5A5A5));
		plan.push_back(typed_row(FN_START, 6'd0, 24'h000000, 0, 24'h0));
		plan.push_back(item_row(FN_TICK, 6'd0, 24'h000000));
		plan.push_back(typed_row(FN_TICK, 6'd0, 24'h000000, 5, 24'h000000));
		plan.push_back(item_row(FN_WRITE_ONE, 6'd40, 24'hFF00FF));
		plan.push_back(typed_row(FN_TICK, 6'd0, 24'h000000, 0, 24'h0));
		// fade down to black, then stopped
		plan.push_back(cfg_row(REG_MODE, MODE_FADE));
		plan.push_back(typed_row(FN_WRITE_ALL, 6'd0, 24'h030201, 5, 24'h030201));
		plan.push_back(typed_row(FN_START, 6'd0, 24'h000000, 0, 24'h0));
		plan.push_back(item_row(FN_TICK, 6'd0, 24'h000000));
		plan.push_back(item_row(FN_TICK, 6'd0, 24'h000000));
		plan.push_back(typed_row(FN_TICK, 6'd0, 24'h000000, 0, 24'h0));
		// breathe on a zero count strip with reversals at both ends
		plan.push_back(cfg_row(REG_MODE, MODE_BREATHE));
		plan.push_back(cfg_row(REG_LED_COUNT, 24'd0));
		plan.push_back(cfg_row(REG_LOW_COLOR, 24'h000100));
		plan.push_back(cfg_row(REG_HIGH_COLOR, 24'h010201));
		plan.push_back(item_row(FN_START, 6'd0, 24'h000000));
		plan.push_back(item_row(FN_TICK, 6'd0, 24'h000000));
		plan.push_back(item_row(FN_TICK, 6'd0, 24'h000000));
		// low above high in red, so the direction never turns
		plan.push_back(cfg_row(REG_LOW_COLOR, 24'h020000));
		plan.push_back(cfg_row(REG_HIGH_COLOR, 24'h000003));
		plan.push_back(item_row(FN_START, 6'd0, 24'h000000));
		plan.push_back(item_row(FN_TICK, 6'd0, 24'h000000));
		// scroll with a window longer than the strip
		plan.push_back(cfg_row(REG_MODE, MODE_SCROLL));
		plan.push_back(cfg_row(REG_LED_COUNT, 24'd4));
		plan.push_back(cfg_row(REG_WIN_LEN, 24'd6));
		plan.push_back(cfg_row(REG_LOW_COLOR, 24'h0000FF));
		plan.push_back(cfg_row(REG_HIGH_COLOR, 24'hFF0000));
		plan.push_back(item_row(FN_START, 6'd0, 24'h000000));
		plan.push_back(item_row(FN_TICK, 6'd0, 24'h000000));
		// mode switched away while running: ticks give nothing
		plan.push_back(cfg_row(REG_MODE, MODE_NONE));
		plan.push_back(typed_row(FN_TICK, 6'd0, 24'h000000, 0, 24'h0));
		plan.push_back(cfg_row(REG_MODE, 24'd7));
		plan.push_back(typed_row(FN_TICK, 6'd0, 24'h000000, 0, 24'h0));
		// back to scroll on one pixel, window start now wraps
		plan.push_back(cfg_row(REG_MODE, MODE_SCROLL));
		plan.push_back(cfg_row(REG_LED_COUNT, 24'd1));
		plan.push_back(item_row(FN_TICK, 6'd0, 24'h000000));
		// count above the store size and an empty window
		plan.push_back(cfg_row(REG_LED_COUNT, 24'd127));
		plan.push_back(cfg_row(REG_WIN_LEN, 24'd0));
		plan.push_back(item_row(FN_TICK, 6'd0, 24'h000000));

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				if (!cfg_open) begin
					drain();
					settings++;
				end
				write_reg(plan[i].sel, plan[i].val);
			end else begin
				send_item(plan[i]);
				directed_items++;
			end
		end

		// random phases: new settings, then mostly start plus ticks
		phase = 0;
		while (random_items < RANDOM_ITEMS) begin
			quiet = (phase >= 5 && phase < 8);
			drain();
			settings++;
			r = $urandom_range(0, 99);
			if (r < 6) v = MODE_NONE;
			else if (r < 10) v = CFG_DATA_W'($urandom_range(5, 7));
			else v = CFG_DATA_W'($urandom_range(1, 4));
			write_reg(REG_MODE, v);
			r = $urandom_range(0, 99);
			if (r < 5) v = '0;
			else if (r < 15) v = CFG_DATA_W'($urandom_range(64, 127));
			else v = CFG_DATA_W'($urandom_range(1, 8));
			write_reg(REG_LED_COUNT, v);
			write_reg(REG_LOW_COLOR, pick_color());
			write_reg(REG_HIGH_COLOR, pick_color());
			r = $urandom_range(0, 99);
			v = (r < 10) ? CFG_DATA_W'($urandom_range(0, 127)) :
				CFG_DATA_W'($urandom_range(0, 6));
			write_reg(REG_WIN_LEN, v);

			started = ($urandom_range(0, 99) < 75);
			n_items = $urandom_range(6, 14);
			for (int k = 0; k < n_items; k++) begin
				r = $urandom_range(0, 99);
				if (k == 0 && started) row = item_row(FN_START, '0, '0);
				else if (r < 70) row = item_row(FN_TICK, '0, '0);
				else if (r < 80) row = item_row(FN_WRITE_ONE, '0, '0);
				else if (r < 88) row = item_row(FN_WRITE_ALL, '0, '0);
				else row = item_row(FN_START, '0, '0);
				row.pos = IDX_W'($urandom_range(0, 63));
				row.rgb = pick_color();
				send_item(row);
				random_items++;
			end
			phase++;
		end
		quiet = 0;
		drain();

		$display("covered %0d directed and %0d random items over %0d register settings",
			directed_items, random_items, settings);
		$display("%0d pixels checked, %0d mismatches", pixels_seen, mismatches);
		if (mismatches == 0 && frame_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
